// ===== rtl/core/sfta_pkg.sv =====
// sfta_pkg: shared types and constants of the strip/fan triangle assembler
// used by sfta_assembler and strip_fan_triangle_assembler_core, no dependencies

package sfta_pkg;

    localparam int IndexWidth = 16;
    localparam int TexWidth   = 32;
    localparam int CountWidth = 16;
    localparam int RunWidth   = 15;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic [IndexWidth-1:0] index;
        logic [TexWidth-1:0]   s;
        logic [TexWidth-1:0]   t;
    } vertex_t;

    typedef struct packed {
        logic                         opcode;
        logic signed [CountWidth-1:0] vertex_count;
        vertex_t                      vtx;
    } in_item_t;

    typedef struct packed {
        vertex_t c0;
        vertex_t c1;
        vertex_t c2;
        logic    run_last;
    } triangle_t;

endpackage

// ===== rtl/core/strip_fan_triangle_assembler_core.sv =====
// strip_fan_triangle_assembler_core: top level with input and result registers
// depends on sfta_pkg and sfta_assembler
//
// Usage: the input channel (in_valid/in_ready) takes run headers (opcode 0,
// signed vertex_count) and vertices (opcode 1, vertex_index, tex_s, tex_t).
// A positive count opens a strip, a negative one a fan, zero ends the list.
// The output channel (out_valid/out_ready) gives one triangle, three corners
// plus run_last, for each vertex from the third of a run on; headers and
// vertices with no open run give nothing.
// An accepted item sits in the input register until the result register can
// take it; its triangle, if it forms one, is then written into the result
// register and offered on the output channel from there.
// Throughput: one item per cycle while the receiver keeps taking triangles;
// the run state and the two held corners are updated as each item advances.
// When the receiver stalls, the triangle holds in the result register and the
// next item waits in the input register; in_ready drops only when both are
// full. Reset clears both valid flags and closes any open run; the held
// corners are not reset and are written before a run reads them.

module strip_fan_triangle_assembler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic signed [sfta_pkg::CountWidth-1:0] vertex_count,
    input  logic [sfta_pkg::IndexWidth-1:0]     vertex_index,
    input  logic [sfta_pkg::TexWidth-1:0]       tex_s,
    input  logic [sfta_pkg::TexWidth-1:0]       tex_t,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sfta_pkg::IndexWidth-1:0]     corner0_index,
    output logic [sfta_pkg::TexWidth-1:0]       corner0_s,
    output logic [sfta_pkg::TexWidth-1:0]       corner0_t,
    output logic [sfta_pkg::IndexWidth-1:0]     corner1_index,
    output logic [sfta_pkg::TexWidth-1:0]       corner1_s,
    output logic [sfta_pkg::TexWidth-1:0]       corner1_t,
    output logic [sfta_pkg::IndexWidth-1:0]     corner2_index,
    output logic [sfta_pkg::TexWidth-1:0]       corner2_s,
    output logic [sfta_pkg::TexWidth-1:0]       corner2_t,
    output logic                                run_last
);

    logic                in_valid_reg, in_valid_next;
    sfta_pkg::in_item_t  item_reg;
    logic                out_valid_reg, out_valid_next;
    sfta_pkg::triangle_t tri_reg;

    logic                advance;
    logic                in_take;
    logic                emit;
    sfta_pkg::triangle_t tri_comb;

    // item leaves the input register once the result register can take it
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    sfta_assembler u_asm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (item_reg),
        .emit    (emit),
        .tri_out (tri_comb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode       <= opcode;
            item_reg.vertex_count <= vertex_count;
            item_reg.vtx.index    <= vertex_index;
            item_reg.vtx.s        <= tex_s;
            item_reg.vtx.t        <= tex_t;
        end
        if (advance && emit)
            tri_reg <= tri_comb;
    end

    assign out_valid     = out_valid_reg;
    assign corner0_index = tri_reg.c0.index;
    assign corner0_s     = tri_reg.c0.s;
    assign corner0_t     = tri_reg.c0.t;
    assign corner1_index = tri_reg.c1.index;
    assign corner1_s     = tri_reg.c1.s;
    assign corner1_t     = tri_reg.c1.t;
    assign corner2_index = tri_reg.c2.index;
    assign corner2_s     = tri_reg.c2.s;
    assign corner2_t     = tri_reg.c2.t;
    assign run_last      = tri_reg.run_last;

endmodule

// ===== rtl/core/sfta_assembler.sv =====
// sfta_assembler: run state, two held corners and triangle forming logic
// depends on sfta_pkg

module sfta_assembler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sfta_pkg::in_item_t  item,
    output logic                emit,
    output sfta_pkg::triangle_t tri_out
);

    logic                           fan_mode_reg, fan_mode_next;
    logic [sfta_pkg::RunWidth-1:0]  run_length_reg, run_length_next;
    logic [sfta_pkg::RunWidth-1:0]  position_reg, position_next;
    sfta_pkg::vertex_t              held0_reg, held0_next;
    sfta_pkg::vertex_t              held1_reg, held1_next;

    logic [sfta_pkg::RunWidth:0]    pos_inc;
    logic [sfta_pkg::CountWidth-1:0] neg_count;
    logic [sfta_pkg::RunWidth-1:0]  fan_len;
    logic                           is_vertex;
    logic                           swap;

    assign is_vertex = (item.opcode == sfta_pkg::OP_VERTEX) && (run_length_reg != '0);
    assign pos_inc   = {1'b0, position_reg} + {{sfta_pkg::RunWidth{1'b0}}, 1'b1};
    assign neg_count = -item.vertex_count;
    // a count of -32768 negates to itself, saturate its length
    assign fan_len   = neg_count[sfta_pkg::CountWidth-1] ? {sfta_pkg::RunWidth{1'b1}}
                                                          : neg_count[sfta_pkg::RunWidth-1:0];
    // odd strip positions swap the held corners to keep the winding
    assign swap      = !fan_mode_reg && position_reg[0];

    always_comb
    begin
        emit             = is_vertex && (position_reg > 15'd1);
        tri_out.c0       = swap ? held1_reg : held0_reg;
        tri_out.c1       = swap ? held0_reg : held1_reg;
        tri_out.c2       = item.vtx;
        tri_out.run_last = (pos_inc == {1'b0, run_length_reg});
    end

    always_comb
    begin
        fan_mode_next   = fan_mode_reg;
        run_length_next = run_length_reg;
        position_next   = position_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        if (item.opcode == sfta_pkg::OP_HEADER)
        begin
            position_next = '0;
            if (item.vertex_count == '0)
            begin
                fan_mode_next   = 1'b0;
                run_length_next = '0;
            end
            else if (!item.vertex_count[sfta_pkg::CountWidth-1])
            begin
                fan_mode_next   = 1'b0;
                run_length_next = item.vertex_count[sfta_pkg::RunWidth-1:0];
            end
            else
            begin
                fan_mode_next   = 1'b1;
                run_length_next = fan_len;
            end
        end
        else if (is_vertex)
        begin
            if (fan_mode_reg)
            begin
                if (position_reg == '0)
                    held0_next = item.vtx;
            end
            else
            begin
                held0_next = held1_reg;
            end
            held1_next = item.vtx;
            if (pos_inc >= {1'b0, run_length_reg})
            begin
                run_length_next = '0;
                position_next   = '0;
                fan_mode_next   = 1'b0;
            end
            else
            begin
                position_next = pos_inc[sfta_pkg::RunWidth-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_mode_reg   <= 1'b0;
            run_length_reg <= '0;
            position_reg   <= '0;
        end
        else if (step)
        begin
            fan_mode_reg   <= fan_mode_next;
            run_length_reg <= run_length_next;
            position_reg   <= position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

// ===== verif/strip_fan_triangle_assembler_core_test.sv =====
// strip_fan_triangle_assembler_core_test: self-checking bench for the strip/fan triangle assembler
// depends on sfta_pkg and strip_fan_triangle_assembler_core; a directed table first, then
// random runs checked item by item against a built-in assembly predictor

module strip_fan_triangle_assembler_core_test;

    localparam int HoldCycles = 48;
    localparam int QuietLimit = 1000;

    typedef struct packed {
        logic                                   opcode;
        logic signed [sfta_pkg::CountWidth-1:0] count;
        sfta_pkg::vertex_t                      vtx;
        logic                                   has_known;
        sfta_pkg::triangle_t                    known_tri;
    } stim_row_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   in_valid;
    logic                                   in_ready;
    logic                                   opcode;
    logic signed [sfta_pkg::CountWidth-1:0] vertex_count;
    logic [sfta_pkg::IndexWidth-1:0]        vertex_index;
    logic [sfta_pkg::TexWidth-1:0]          tex_s;
    logic [sfta_pkg::TexWidth-1:0]          tex_t;
    logic                                   out_valid;
    logic                                   out_ready;
    logic [sfta_pkg::IndexWidth-1:0]        corner0_index;
    logic [sfta_pkg::TexWidth-1:0]          corner0_s;
    logic [sfta_pkg::TexWidth-1:0]          corner0_t;
    logic [sfta_pkg::IndexWidth-1:0]        corner1_index;
    logic [sfta_pkg::TexWidth-1:0]          corner1_s;
    logic [sfta_pkg::TexWidth-1:0]          corner1_t;
    logic [sfta_pkg::IndexWidth-1:0]        corner2_index;
    logic [sfta_pkg::TexWidth-1:0]          corner2_s;
    logic [sfta_pkg::TexWidth-1:0]          corner2_t;
    logic                                   run_last;

    // predictor state
    logic                          asm_fan;
    logic [sfta_pkg::RunWidth-1:0] asm_len;
    logic [sfta_pkg::RunWidth-1:0] asm_pos;
    sfta_pkg::vertex_t             held_corner [2];

    sfta_pkg::triangle_t pending_triangles [$];
    stim_row_t           directed_rows [$];

    bit idle_enable;
    bit hold_off_req;
    int mismatches;
    int n_headers;
    int n_vertices;
    int n_stray;
    int n_strips;
    int n_fans;
    int n_triangles;
    int n_last;

    strip_fan_triangle_assembler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .vertex_count  (vertex_count),
        .vertex_index  (vertex_index),
        .tex_s         (tex_s),
        .tex_t         (tex_t),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .corner0_index (corner0_index),
        .corner0_s     (corner0_s),
        .corner0_t     (corner0_t),
        .corner1_index (corner1_index),
        .corner1_s     (corner1_s),
        .corner1_t     (corner1_t),
        .corner2_index (corner2_index),
        .corner2_s     (corner2_s),
        .corner2_t     (corner2_t),
        .run_last      (run_last)
    );

    always #4 clk = ~clk;

    // one item through the assembler; returns 1 when it closes a triangle
    function automatic bit assemble(input logic op,
                                    input logic signed [sfta_pkg::CountWidth-1:0] cnt,
                                    input sfta_pkg::vertex_t v,
                                    output sfta_pkg::triangle_t tri_out);
        int                mag;
        sfta_pkg::vertex_t first;
        sfta_pkg::vertex_t second;
        bit                emitted;
        tri_out = '0;
        emitted = 1'b0;
        if (op == sfta_pkg::OP_HEADER)
        begin
            asm_pos = '0;
            if (cnt == 0)
            begin
                asm_fan = 1'b0;
                asm_len = '0;
            end
            else if (cnt > 0)
            begin
                asm_fan = 1'b0;
                asm_len = cnt[sfta_pkg::RunWidth-1:0];
                n_strips++;
            end
            else
            begin
                // a count of -32768 saturates to the longest run
                mag = -int'(cnt);
                asm_fan = 1'b1;
                asm_len = (mag > 32767) ? 15'h7FFF : mag[sfta_pkg::RunWidth-1:0];
                n_fans++;
            end
            return 1'b0;
        end
        if (asm_len == 0)
            return 1'b0;
        if (asm_pos > 1)
        begin
            // odd strip positions swap the held pair to keep the winding
            if (!asm_fan && asm_pos[0])
            begin
                first = held_corner[1];
                second = held_corner[0];
            end
            else
            begin
                first = held_corner[0];
                second = held_corner[1];
            end
            tri_out.c0 = first;
            tri_out.c1 = second;
            tri_out.c2 = v;
            tri_out.run_last = (int'(asm_pos) + 1 == int'(asm_len));
            emitted = 1'b1;
        end
        if (asm_fan)
        begin
            if (asm_pos == 0)
                held_corner[0] = v;
        end
        else
            held_corner[0] = held_corner[1];
        held_corner[1] = v;
        if (int'(asm_pos) + 1 >= int'(asm_len))
        begin
            asm_len = '0;
            asm_pos = '0;
            asm_fan = 1'b0;
        end
        else
            asm_pos = asm_pos + 1'b1;
        return emitted;
    endfunction

    function automatic stim_row_t mk_row(input logic op,
                                         input logic signed [sfta_pkg::CountWidth-1:0] cnt,
                                         input sfta_pkg::vertex_t v);
        stim_row_t row;
        row = '0;
        row.opcode = op;
        row.count = cnt;
        row.vtx = v;
        return row;
    endfunction

    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic sfta_pkg::vertex_t random_vertex();
        sfta_pkg::vertex_t v;
        v.index = $urandom_range(0, 65535);
        v.s = $urandom;
        v.t = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, want %h", field, got, want);
        mismatches++;
    endtask

    task automatic check_triangle(input sfta_pkg::triangle_t got);
        sfta_pkg::triangle_t want;
        sfta_pkg::vertex_t   gv [3];
        sfta_pkg::vertex_t   wv [3];
        if (pending_triangles.size() == 0)
        begin
            report_mismatch("corner2_index of a triangle with nothing pending",
                            32'(got.c2.index), 32'd0);
            return;
        end
        want = pending_triangles.pop_front();
        gv[0] = got.c0;
        gv[1] = got.c1;
        gv[2] = got.c2;
        wv[0] = want.c0;
        wv[1] = want.c1;
        wv[2] = want.c2;
        for (int k = 0; k < 3; k++)
        begin
            if (gv[k].index !== wv[k].index)
                report_mismatch($sformatf("corner%0d_index", k), 32'(gv[k].index),
                                32'(wv[k].index));
            if (gv[k].s !== wv[k].s)
                report_mismatch($sformatf("corner%0d_s", k), gv[k].s, wv[k].s);
            if (gv[k].t !== wv[k].t)
                report_mismatch($sformatf("corner%0d_t", k), gv[k].t, wv[k].t);
        end
        if (got.run_last !== want.run_last)
            report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
        n_triangles++;
        if (want.run_last)
            n_last++;
    endtask

    // called at an edge; returns at the edge where the item is taken
    task automatic offer_item(input stim_row_t row);
        sfta_pkg::triangle_t tri_pred;
        bit                  stray;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= row.opcode;
        vertex_count <= row.count;
        vertex_index <= row.vtx.index;
        tex_s <= row.vtx.s;
        tex_t <= row.vtx.t;
        do @(posedge clk); while (!in_ready);
        stray = (row.opcode == sfta_pkg::OP_VERTEX) && (asm_len == 0);
        if (assemble(row.opcode, row.count, row.vtx, tri_pred))
            pending_triangles.insert(pending_triangles.size(),
                                     row.has_known ? row.known_tri : tri_pred);
        if (stray)
            n_stray++;
        else if (row.opcode == sfta_pkg::OP_HEADER)
            n_headers++;
        else
            n_vertices++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_triangles.size() != 0);
    endtask

    // mostly complete runs with random content, some cut short, stray vertices and
    // headers with any count mixed in
    task automatic random_traffic(input int n_items, input bit allow_idle);
        int  target;
        int  len;
        int  cut;
        bit  fan;
        if (!allow_idle)
            idle_enable = 1'b0;
        target = n_headers + n_vertices + n_items;
        while (n_headers + n_vertices < target)
        begin
            if (allow_idle && $urandom_range(0, 30) == 0)
                idle_enable = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 15))
                0: offer_item(mk_row(sfta_pkg::OP_HEADER, '0, random_vertex()));
                1:
                begin
                    if (asm_len == 0)
                        offer_item(mk_row(sfta_pkg::OP_VERTEX, 16'($urandom),
                                          random_vertex()));
                end
                2:
                begin
                    offer_item(mk_row(sfta_pkg::OP_HEADER, 16'($urandom), random_vertex()));
                    repeat ($urandom_range(0, 4))
                        offer_item(mk_row(sfta_pkg::OP_VERTEX, 16'($urandom),
                                          random_vertex()));
                end
                default:
                begin
                    len = ($urandom_range(0, 30) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 8);
                    fan = $urandom_range(0, 1);
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
                    offer_item(mk_row(sfta_pkg::OP_HEADER, 16'(fan ? -len : len),
                                      random_vertex()));
                    repeat (cut)
                        offer_item(mk_row(sfta_pkg::OP_VERTEX, 16'($urandom),
                                          random_vertex()));
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_triangle({corner0_index, corner0_s, corner0_t,
                            corner1_index, corner1_s, corner1_t,
                            corner2_index, corner2_s, corner2_t, run_last});
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (stall_left > 0)
                stall_left--;
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HoldCycles;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 4);
            out_ready <= (stall_left == 0);
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", QuietLimit);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        sfta_pkg::vertex_t va;
        sfta_pkg::vertex_t vb;
        sfta_pkg::vertex_t vc;
        sfta_pkg::vertex_t fa;
        sfta_pkg::vertex_t fb;
        sfta_pkg::vertex_t fc;
        stim_row_t         row;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = sfta_pkg::OP_HEADER;
        vertex_count = '0;
        vertex_index = '0;
        tex_s = '0;
        tex_t = '0;
        asm_fan = 1'b0;
        asm_len = '0;
        asm_pos = '0;
        held_corner[0] = '0;
        held_corner[1] = '0;
        idle_enable = 1'b1;
        hold_off_req = 1'b0;
        mismatches = 0;

        va = '0;
        vb = '1;
        vc = {16'h1234, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
        fa = {16'h8001, 32'h8000_0000, 32'h0000_0001};
        fb = {16'h7FFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE};
        fc = {16'h00F0, 32'h0F0F_0F0F, 32'hF0F0_F0F0};

        // strip of three, then a vertex after it closed by itself
        add_row(mk_row(sfta_pkg::OP_HEADER, 16'sd3, '1));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '1, va));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, vb));
        row = mk_row(sfta_pkg::OP_VERTEX, '0, vc);
        row.has_known = 1'b1;
        row.known_tri = {va, vb, vc, 1'b1};
        add_row(row);
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'h4321, 32'h1, 32'h2}));
        // strip of four: even then odd position
        add_row(mk_row(sfta_pkg::OP_HEADER, 16'sd4, '0));
        for (int k = 0; k < 4; k++)
            add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'(k + 16), 32'(k * 3), 32'(~k)}));
        // fan of three
        add_row(mk_row(sfta_pkg::OP_HEADER, -16'sd3, '0));
        for (int k = 0; k < 3; k++)
            add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'(k + 32), 32'(k << 28), 32'(k)}));
        // most negative count, then abandoned by a new header
        add_row(mk_row(sfta_pkg::OP_HEADER, 16'sh8000, '0));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, fa));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, fb));
        row = mk_row(sfta_pkg::OP_VERTEX, '0, fc);
        row.has_known = 1'b1;
        row.known_tri = {fa, fb, fc, 1'b0};
        add_row(row);
        add_row(mk_row(sfta_pkg::OP_HEADER, 16'sh7FFF, '0));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'h0055, 32'h55, 32'hAA}));
        // zero header closes the open run
        add_row(mk_row(sfta_pkg::OP_HEADER, '0, '0));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'h0066, 32'h66, 32'h99}));
        // fan too short for a triangle
        add_row(mk_row(sfta_pkg::OP_HEADER, -16'sd2, '0));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'h0077, 32'h77, 32'h88}));
        add_row(mk_row(sfta_pkg::OP_VERTEX, '0, {16'h0078, 32'h78, 32'h87}));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i]);
        pause_until_drained();

        random_traffic(300, 1'b1);
        // long receiver stall while the sender keeps going
        hold_off_req = 1'b1;
        random_traffic(150, 1'b1);
        pause_until_drained();
        random_traffic(330, 1'b1);
        random_traffic(120, 1'b0);
        in_valid <= 1'b0;

        while (pending_triangles.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d headers (%0d strips, %0d fans opened), %0d run vertices, %0d strays",
                 n_headers, n_strips, n_fans, n_vertices, n_stray);
        $display("checked %0d triangles, %0d of them closing a run", n_triangles, n_last);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
